@@ design/paq_pkg.sv @@
// ----------------------------------------------------------------------------
// paq_pkg
// Shared types, codes and helpers for the periodic alarm queue.
// ----------------------------------------------------------------------------
package paq_pkg;

  localparam int TIME_W         = 63;
  localparam int OP_W           = 3;
  localparam int SLOT_W         = 3;
  localparam int NUM_ALARMS_DEF = 8;
  localparam int MAX_RESULTS    = 8;
  localparam int NRES_W         = $clog2(MAX_RESULTS + 1);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam op_t OP_SET_REL = 3'd0;
  localparam op_t OP_SET_ABS = 3'd1;
  localparam op_t OP_SET_PER = 3'd2;
  localparam op_t OP_CANCEL  = 3'd3;
  localparam op_t OP_POLL    = 3'd4;

  localparam time_t TIME_MAX = {TIME_W{1'b1}};

  // Saturating sum of two times; the raw sum never wraps in TIME_W+1 bits.
  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

@@ design/paq_ram.sv @@
// ----------------------------------------------------------------------------
// paq_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module paq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/periodic_alarm_queue.sv @@
// ----------------------------------------------------------------------------
// periodic_alarm_queue
// Table of alarm slots with fire times and periods, kept in a queue list.
// ----------------------------------------------------------------------------
// Usage: drive in_* and pulse start while busy is low; the command beat is
// taken at that edge and busy rises on the next cycle. Set, cancel and
// unknown commands give one status beat (out_alarm_fired low). A poll gives
// one beat per due alarm (at most MAX_RESULTS) in queue order, or one status
// beat if none is due. out_last_result marks the final beat of a command.
// Each beat is valid for exactly one cycle on out_valid; the receiver
// cannot stall. Set, absolute set and cancel give their status beat from
// the dispatch step. A periodic set whose start lies in the past first runs
// the remainder step. A poll reads the queued slots in order from the time
// RAM (registered read) and runs the remainder step for each periodic alarm
// that must be caught up past now; the bit-serial remainder unit takes one
// dividend bit per cycle. A new command is taken when busy is low.
// Reset clears the armed flags and the queue length; fire times and periods
// in the RAM stay undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module periodic_alarm_queue #(
  parameter int NUM_ALARMS = paq_pkg::NUM_ALARMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  paq_pkg::op_t    in_operation,
  input  paq_pkg::slot_t  in_slot,
  input  paq_pkg::time_t  in_current_time,
  input  paq_pkg::time_t  in_time_value,
  input  paq_pkg::time_t  in_period_ticks,
  output logic            out_valid,
  output logic            out_alarm_fired,
  output paq_pkg::slot_t  out_fired_slot,
  output logic            out_was_periodic,
  output logic            out_last_result,
  output logic            out_queue_not_empty
);
  import paq_pkg::*;

  localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int LEN_W = $clog2(NUM_ALARMS + 1);
  localparam int CNT_W = $clog2(TIME_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_PRD  = 3'd2;
  localparam logic [2:0] ST_PCHK = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIX  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  op_t                   op_r, op_nxt;
  slot_t                 slot_r, slot_nxt;
  time_t                 now_r, now_nxt, val_r, val_nxt, per_r, per_nxt;
  logic [NUM_ALARMS-1:0] armed_r, armed_nxt;
  logic [IDX_W-1:0]      qo_r [NUM_ALARMS];
  logic [IDX_W-1:0]      qo_nxt [NUM_ALARMS];
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      i_r, i_nxt;
  logic [NRES_W-1:0]     n_r, n_nxt;
  logic [IDX_W-1:0]      a_r, a_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]      pend_slot_r, pend_slot_nxt;
  logic                  pend_per_r, pend_per_nxt;
  time_t                 dq_r, dq_nxt, rem_r, rem_nxt, dsor_r, dsor_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  div_poll_r, div_poll_nxt;
  logic                  ov_r, ov_nxt, ofire_r, ofire_nxt, oper_r, oper_nxt;
  logic                  olast_r, olast_nxt, oqne_r, oqne_nxt;
  slot_t                 oslot_r, oslot_nxt;

  // RAM word: fire time in the upper half, period in the lower half
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [2*TIME_W-1:0]    ram_wdata, ram_rdata;
  time_t                  rd_fire, rd_per;

  // structure edit requests
  logic                   do_link, do_remove, emit_status, do_push, push_per;
  logic [IDX_W-1:0]       link_idx, remove_pos, push_slot, slot_idx;
  logic                   slot_ok;
  time_t                  f_sum, fixed_fire;
  logic [TIME_W:0]        div_t;

  paq_ram #(.WIDTH(2*TIME_W), .DEPTH(NUM_ALARMS)) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_fire    = ram_rdata[2*TIME_W-1:TIME_W];
  assign rd_per     = ram_rdata[TIME_W-1:0];
  assign slot_idx   = IDX_W'(slot_r);
  assign slot_ok    = 32'(slot_r) < NUM_ALARMS;
  assign f_sum      = sat_add(rd_fire, rd_per);
  assign fixed_fire = sat_add(now_r - rem_r, dsor_r);
  assign div_t      = {rem_r, dq_r[TIME_W-1]};
  assign busy       = (state_r != ST_IDLE);

  always_comb begin
    logic [IDX_W-1:0] cpos;
    cpos          = '0;
    state_nxt     = state_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    now_nxt       = now_r;
    val_nxt       = val_r;
    per_nxt       = per_r;
    armed_nxt     = armed_r;
    qo_nxt        = qo_r;
    len_nxt       = len_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    a_nxt         = a_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_per_nxt  = pend_per_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dsor_nxt      = dsor_r;
    cnt_nxt       = cnt_r;
    div_poll_nxt  = div_poll_r;
    ov_nxt        = 1'b0;
    ofire_nxt     = ofire_r;
    oslot_nxt     = oslot_r;
    oper_nxt      = oper_r;
    olast_nxt     = olast_r;
    oqne_nxt      = oqne_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_idx;
    ram_wdata     = '0;
    ram_raddr     = qo_r[i_r[IDX_W-1:0]];
    do_link       = 1'b0;
    link_idx      = slot_idx;
    do_remove     = 1'b0;
    remove_pos    = '0;
    emit_status   = 1'b0;
    do_push       = 1'b0;
    push_slot     = a_r;
    push_per      = 1'b0;

    for (int k = 0; k < NUM_ALARMS; k++) begin
      if (32'(k) < 32'(len_r) && qo_r[k] == slot_idx) begin
        cpos = cpos | IDX_W'(k);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          slot_nxt  = in_slot;
          now_nxt   = in_current_time;
          val_nxt   = in_time_value;
          per_nxt   = in_period_ticks;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        if (op_r == OP_POLL) begin
          i_nxt      = '0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_PRD;
        end else if (op_r <= OP_CANCEL && slot_ok) begin
          if (op_r == OP_CANCEL) begin
            if (armed_r[slot_idx]) begin
              armed_nxt[slot_idx] = 1'b0;
              do_remove  = 1'b1;
              remove_pos = cpos;
            end
            emit_status = 1'b1;
            state_nxt   = ST_IDLE;
          end else if (op_r == OP_SET_PER && per_r != '0 && val_r <= now_r) begin
            // start lies in the past: catch up via the remainder
            dq_nxt       = now_r - val_r;
            rem_nxt      = '0;
            cnt_nxt      = '0;
            dsor_nxt     = per_r;
            div_poll_nxt = 1'b0;
            state_nxt    = ST_DIV;
          end else begin
            ram_we = 1'b1;
            case (op_r)
              OP_SET_REL: ram_wdata = {sat_add(now_r, val_r), TIME_W'(0)};
              OP_SET_ABS: ram_wdata = {val_r, TIME_W'(0)};
              default:    ram_wdata = {val_r, per_r};
            endcase
            do_link     = 1'b1;
            emit_status = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else begin
          emit_status = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_PRD: begin
        if (i_r >= len_r || 32'(n_r) == MAX_RESULTS) begin
          if (pend_v_r) begin
            ov_nxt    = 1'b1;
            ofire_nxt = 1'b1;
            oslot_nxt = SLOT_W'(pend_slot_r);
            oper_nxt  = pend_per_r;
            olast_nxt = 1'b1;
            oqne_nxt  = (len_r != '0);
          end else begin
            emit_status = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          a_nxt     = qo_r[i_r[IDX_W-1:0]];
          state_nxt = ST_PCHK;
        end
      end
      ST_PCHK: begin
        if (armed_r[a_r] && rd_fire <= now_r) begin
          if (rd_per == '0) begin
            // one-shot: disarm and drop from the list, index stays
            armed_nxt[a_r] = 1'b0;
            do_remove  = 1'b1;
            remove_pos = i_r[IDX_W-1:0];
            do_push    = 1'b1;
            state_nxt  = ST_PRD;
          end else if (f_sum <= now_r) begin
            dq_nxt       = now_r - f_sum;
            rem_nxt      = '0;
            cnt_nxt      = '0;
            dsor_nxt     = rd_per;
            div_poll_nxt = 1'b1;
            state_nxt    = ST_DIV;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = a_r;
            ram_wdata = {f_sum, rd_per};
            i_nxt     = i_r + LEN_W'(1);
            do_push   = 1'b1;
            push_per  = 1'b1;
            state_nxt = ST_PRD;
          end
        end else begin
          i_nxt     = i_r + LEN_W'(1);
          state_nxt = ST_PRD;
        end
      end
      ST_DIV: begin
        // one dividend bit per cycle
        dq_nxt  = {dq_r[TIME_W-2:0], 1'b0};
        rem_nxt = (div_t >= {1'b0, dsor_r}) ? TIME_W'(div_t - {1'b0, dsor_r})
                                            : div_t[TIME_W-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TIME_W - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        ram_we    = 1'b1;
        ram_wdata = {fixed_fire, dsor_r};
        if (div_poll_r) begin
          ram_waddr = a_r;
          i_nxt     = i_r + LEN_W'(1);
          do_push   = 1'b1;
          push_per  = 1'b1;
          state_nxt = ST_PRD;
        end else begin
          do_link     = 1'b1;
          emit_status = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_remove) begin
      for (int k = 0; k < NUM_ALARMS - 1; k++) begin
        if (IDX_W'(k) >= remove_pos) begin
          qo_nxt[k] = qo_r[k+1];
        end
      end
      len_nxt = len_r - LEN_W'(1);
    end

    if (do_link && !armed_r[link_idx]) begin
      for (int k = 1; k < NUM_ALARMS; k++) begin
        qo_nxt[k] = qo_r[k-1];
      end
      qo_nxt[0] = link_idx;
      len_nxt   = len_r + LEN_W'(1);
    end
    if (do_link) begin
      armed_nxt[link_idx] = 1'b1;
    end

    if (emit_status) begin
      ov_nxt    = 1'b1;
      ofire_nxt = 1'b0;
      oslot_nxt = '0;
      oper_nxt  = 1'b0;
      olast_nxt = 1'b1;
      oqne_nxt  = (len_nxt != '0);
    end

    if (do_push) begin
      // hold the newest beat; release the previous one as not last
      n_nxt = n_r + NRES_W'(1);
      if (pend_v_r) begin
        ov_nxt    = 1'b1;
        ofire_nxt = 1'b1;
        oslot_nxt = SLOT_W'(pend_slot_r);
        oper_nxt  = pend_per_r;
        olast_nxt = 1'b0;
        oqne_nxt  = (len_r != '0);
      end
      pend_v_nxt    = 1'b1;
      pend_slot_nxt = push_slot;
      pend_per_nxt  = push_per;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      armed_r  <= '0;
      len_r    <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      armed_r  <= armed_nxt;
      len_r    <= len_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    slot_r      <= slot_nxt;
    now_r       <= now_nxt;
    val_r       <= val_nxt;
    per_r       <= per_nxt;
    qo_r        <= qo_nxt;
    i_r         <= i_nxt;
    n_r         <= n_nxt;
    a_r         <= a_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_per_r  <= pend_per_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    dsor_r      <= dsor_nxt;
    cnt_r       <= cnt_nxt;
    div_poll_r  <= div_poll_nxt;
    ofire_r     <= ofire_nxt;
    oslot_r     <= oslot_nxt;
    oper_r      <= oper_nxt;
    olast_r     <= olast_nxt;
    oqne_r      <= oqne_nxt;
  end

  assign out_valid           = ov_r;
  assign out_alarm_fired     = ofire_r;
  assign out_fired_slot      = oslot_r;
  assign out_was_periodic    = oper_r;
  assign out_last_result     = olast_r;
  assign out_queue_not_empty = oqne_r;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= NUM_ALARMS) else $error("queue length out of range");
  a_len_armed: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(armed_r) == 32'(len_r)) else $error("armed count differs from length");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ofire_r |-> olast_r) else $error("status beat not marked last");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("command taken without going busy");
`endif

endmodule
